>>> rtl/core/cvq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvq_pkg
// shared types and constants for the 2-d competitive learning quantizer
// ----------------------------------------------------------------------------
package cvq_pkg;

    localparam int NUM_PROTOTYPES_DEF = 10;
    localparam logic [15:0] LEARNING_RATE_RST = 16'd6554;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TRAIN = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIRECT,
        ST_READ,
        ST_RWAIT,
        ST_SCAN,
        ST_DRAIN,
        ST_UPD1,
        ST_UPD2
    } state_t;

endpackage

>>> rtl/core/cvq_move.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvq_move
// moves one coordinate toward the sample by eta * (s - w), floor shift by 16
// ----------------------------------------------------------------------------
module cvq_move (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] w,
    input  logic signed [15:0] s,
    input  logic        [15:0] eta,
    output logic signed [15:0] w_new
);
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [33:0] prod_reg;
    logic signed [15:0] w_reg;
    logic signed [17:0] sum;

    assign diff = $signed({s[15], s}) - $signed({w[15], w});
    assign prod = diff * $signed({1'b0, eta});

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod;
            w_reg    <= w;
        end
    end

    assign sum   = $signed({{2{w_reg[15]}}, w_reg}) + $signed(prod_reg[33:16]);
    assign w_new = sum[15:0];

endmodule

>>> rtl/core/competitive_learning_vq_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// competitive_learning_vq_2d
// winner-take-all vector quantizer over a memory of 2-d prototypes
// ----------------------------------------------------------------------------
//  channel   dir  handshake               contents
//  s_axis    in   s_axis_tvalid/tready    tuser: opcode, tdata: slot, x, y
//  m_axis    out  m_axis_tvalid/tready    tdata: winner, distance, x, y
//  cfg       in   cfg_we                  cfg_wdata: learning rate
//
//  train passes the accept cycle, one memory read per prototype, then a drain
//  of the distance pipeline and an update in the states ST_UPD1 and ST_UPD2
//  load uses ST_DIRECT; read uses ST_READ, then ST_RWAIT for the registered read
//  reset is synchronous, active low; memory contents are not cleared
//  a new word is taken while the last result waits in the output register;
//  a finished item holds in its last state until that register frees
// ----------------------------------------------------------------------------
module competitive_learning_vq_2d #(
    parameter int NUM_PROTOTYPES = cvq_pkg::NUM_PROTOTYPES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // proto_index, sample_x, sample_y, zero pad
    input  logic [1:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // winner_index, squared_distance, proto_x,
                                        // proto_y, zero pad
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import cvq_pkg::*;

    localparam int AW = $clog2(NUM_PROTOTYPES);
    localparam int IW = ((AW > 4) ? AW : 4) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PROTOTYPES - 1);

    state_t state_reg, state_next;

    logic               s_acc;
    logic               out_free;
    opcode_t            op_reg;
    logic [3:0]         slot_reg;
    logic signed [15:0] sx_reg, sy_reg;
    logic [15:0]        learning_rate_reg;
    logic [IW-1:0]      slot_wide;
    logic [AW-1:0]      slot_addr;
    logic               slot_ok;

    logic [31:0]        mem [NUM_PROTOTYPES];
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [31:0]        mem_wdata;
    logic [31:0]        rd_data_reg;

    logic [AW-1:0]      scan_addr_reg;
    logic               v0_reg, v1_reg, v2_reg;
    logic [AW-1:0]      idx0_reg, idx1_reg, idx2_reg;
    logic signed [16:0] dx1_reg, dy1_reg;
    logic signed [15:0] px1_reg, py1_reg, px2_reg, py2_reg;
    logic signed [33:0] mulx, muly;
    logic [31:0]        sqx2_reg, sqy2_reg;
    logic [32:0]        dsum;
    logic [32:0]        best_reg;
    logic [AW-1:0]      best_idx_reg;
    logic signed [15:0] bx_reg, by_reg;
    logic [IW-1:0]      best_wide;

    logic               move_en;
    logic signed [15:0] new_x, new_y;

    logic               out_ld;
    logic [3:0]         out_idx;
    logic [32:0]        out_dist;
    logic [15:0]        out_x, out_y;
    logic               m_valid_reg;
    logic [3:0]         m_idx_reg;
    logic [32:0]        m_dist_reg;
    logic [15:0]        m_x_reg, m_y_reg;

    assign s_acc     = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign slot_wide = IW'(slot_reg);
    assign slot_addr = slot_wide[AW-1:0];
    assign slot_ok   = slot_wide < IW'(NUM_PROTOTYPES);
    assign best_wide = IW'(best_idx_reg);

    // learning rate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learning_rate_reg <= LEARNING_RATE_RST;
        end else if (cfg_we) begin
            learning_rate_reg <= cfg_wdata;
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg   <= opcode_t'(s_axis_tuser);
            slot_reg <= s_axis_tdata[3:0];
            sx_reg   <= s_axis_tdata[19:4];
            sy_reg   <= s_axis_tdata[35:20];
        end
    end

    // prototype memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // scan address
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            scan_addr_reg <= '0;
        end else if (state_reg == ST_SCAN && scan_addr_reg != LAST_ADDR) begin
            scan_addr_reg <= scan_addr_reg + AW'(1);
        end
    end

    // distance pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v0_reg <= (state_reg == ST_SCAN);
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    assign mulx = dx1_reg * dx1_reg;
    assign muly = dy1_reg * dy1_reg;
    assign dsum = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};

    // distance pipeline data and running minimum
    always_ff @(posedge aclk) begin
        idx0_reg <= scan_addr_reg;

        idx1_reg <= idx0_reg;
        px1_reg  <= rd_data_reg[15:0];
        py1_reg  <= rd_data_reg[31:16];
        dx1_reg  <= $signed({sx_reg[15], sx_reg})
                    - $signed({rd_data_reg[15], rd_data_reg[15:0]});
        dy1_reg  <= $signed({sy_reg[15], sy_reg})
                    - $signed({rd_data_reg[31], rd_data_reg[31:16]});

        idx2_reg <= idx1_reg;
        px2_reg  <= px1_reg;
        py2_reg  <= py1_reg;
        sqx2_reg <= mulx[31:0];
        sqy2_reg <= muly[31:0];

        if (s_acc) begin
            best_reg <= '1;
        end else if (v2_reg && dsum <= best_reg) begin
            best_reg     <= dsum;
            best_idx_reg <= idx2_reg;
            bx_reg       <= px2_reg;
            by_reg       <= py2_reg;
        end
    end

    cvq_move u_move_x (
        .aclk  (aclk),
        .en    (move_en),
        .w     (bx_reg),
        .s     (sx_reg),
        .eta   (learning_rate_reg),
        .w_new (new_x)
    );

    cvq_move u_move_y (
        .aclk  (aclk),
        .en    (move_en),
        .w     (by_reg),
        .s     (sy_reg),
        .eta   (learning_rate_reg),
        .w_new (new_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = slot_addr;
        mem_wdata  = {sy_reg, sx_reg};
        mem_re     = 1'b0;
        mem_raddr  = scan_addr_reg;
        move_en    = 1'b0;
        out_ld     = 1'b0;
        out_idx    = slot_reg;
        out_dist   = '0;
        out_x      = '0;
        out_y      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (opcode_t'(s_axis_tuser))
                        OP_TRAIN: state_next = ST_SCAN;
                        OP_READ:  state_next = ST_READ;
                        OP_LOAD,
                        OP_NONE:  state_next = ST_DIRECT;
                    endcase
                end
            end
            ST_DIRECT: begin
                if (op_reg == OP_LOAD) begin
                    if (slot_ok) begin
                        out_x = sx_reg;
                        out_y = sy_reg;
                    end
                end else begin
                    out_idx = '0;
                end
                if (out_free) begin
                    mem_we     = (op_reg == OP_LOAD) && slot_ok;
                    out_ld     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                mem_re     = slot_ok;
                mem_raddr  = slot_addr;
                state_next = ST_RWAIT;
            end
            ST_RWAIT: begin
                if (slot_ok) begin
                    out_x = rd_data_reg[15:0];
                    out_y = rd_data_reg[31:16];
                end
                if (out_free) begin
                    out_ld     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                mem_re = 1'b1;
                if (scan_addr_reg == LAST_ADDR) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!(v0_reg || v1_reg || v2_reg)) begin
                    state_next = ST_UPD1;
                end
            end
            ST_UPD1: begin
                move_en    = 1'b1;
                state_next = ST_UPD2;
            end
            ST_UPD2: begin
                mem_waddr = best_idx_reg;
                mem_wdata = {new_y, new_x};
                out_idx   = best_wide[3:0];
                out_dist  = best_reg;
                out_x     = new_x;
                out_y     = new_y;
                if (out_free) begin
                    mem_we     = 1'b1;
                    out_ld     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ld) begin
            m_idx_reg  <= out_idx;
            m_dist_reg <= out_dist;
            m_x_reg    <= out_x;
            m_y_reg    <= out_y;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, m_y_reg, m_x_reg, m_dist_reg, m_idx_reg};

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    a_no_write_during_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !(v0_reg || v1_reg || v2_reg))
        else $error("memory written while distance pipeline busy");

    a_update_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD1) |-> !(v0_reg || v1_reg || v2_reg))
        else $error("update started before scan drained");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DIRECT
            || $past(state_reg) == ST_RWAIT || $past(state_reg) == ST_UPD2))
        else $error("result word raised outside a finishing state");
`endif

endmodule
